FILE: hw/rtl/cfgm_pkg.sv
// ---------------------------------------------------------------------------
// cfgm_pkg
// Shared types and constants for the cube face grid mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package cfgm_pkg;

    localparam int DIR_W  = 16;   // direction component width, signed Q1.15
    localparam int CELL_W = 11;   // cells_per_side register width
    localparam int GRID_W = 10;   // grid column / row field width
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // register indexes
    localparam logic REG_CELLS_PER_SIDE = 1'b0;

    typedef enum logic [2:0] {
        FACE_POS_Z = 3'd0,
        FACE_NEG_Z = 3'd1,
        FACE_POS_X = 3'd2,
        FACE_NEG_X = 3'd3,
        FACE_POS_Y = 3'd4,
        FACE_NEG_Y = 3'd5
    } t_face;

endpackage

`default_nettype wire

FILE: hw/rtl/cfgm_if.sv
// ---------------------------------------------------------------------------
// cfgm_if
// Valid/ready channels: direction in, face and grid cell out.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfgm_dir_if
    import cfgm_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DIR_W-1:0]  dir_x;
    logic signed [DIR_W-1:0]  dir_y;
    logic signed [DIR_W-1:0]  dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cfgm_cell_if
    import cfgm_pkg::*;
;
    logic               valid;
    logic               ready;
    t_face              face_index;
    logic [GRID_W-1:0]  grid_column;
    logic [GRID_W-1:0]  grid_row;

    modport source (output valid, output face_index, output grid_column, output grid_row,
                    input ready);
    modport sink   (input valid, input face_index, input grid_column, input grid_row,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cube_face_grid_mapper.sv
// ---------------------------------------------------------------------------
// cube_face_grid_mapper
// Direction vector to cube face and grid cell, exact rational arithmetic.
// ---------------------------------------------------------------------------
//  channel   dir   protocol     payload
//  i_dir     in    valid/ready  dir_x, dir_y, dir_z (s16 each)
//  o_cell    out   valid/ready  face_index (3), grid_column (10), grid_row (10)
//  apb       in    APB write/rd cells_per_side at byte address 0
//
//  One transaction per cycle while o_cell is not stalled; NW = clog2(MAX+1)
//  is the quotient width. Depth is set by the restoring dividers, one
//  quotient bit per stage. Each stage loads when it is empty or the stage after
//  it moves, so bubbles collapse under stall. Synchronous active-low reset
//  clears valid bits and sets cells_per_side to 1.
// ---------------------------------------------------------------------------
`default_nettype none

module cube_face_grid_mapper
    import cfgm_pkg::*;
#(
    parameter int MAX_CELLS_PER_SIDE = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    cfgm_dir_if.sink                i_dir,
    cfgm_cell_if.source             o_cell,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [APB_AW-1:0]  i_paddr,
    input  wire logic [APB_DW-1:0]  i_pwdata,
    output logic      [APB_DW-1:0]  o_prdata,
    output logic                    o_pready
);

    localparam int NW   = $clog2(MAX_CELLS_PER_SIDE + 1);  // N and quotient width
    localparam int PW   = DIR_W + 1;                       // numerator before scaling
    localparam int NUMW = PW + NW;

    // ---------------- configuration ----------------
    logic [CELL_W-1:0] r_cells;
    logic [31:0]       w_n32;
    logic [NW-1:0]     w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= CELL_W'(1);
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr[2] == REG_CELLS_PER_SIDE) begin
            r_cells <= i_pwdata[CELL_W-1:0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_CELLS_PER_SIDE) ? APB_DW'(r_cells) : '0;

    always_comb begin
        if (r_cells == '0) begin
            w_n32 = 32'd1;
        end else if (32'(r_cells) > 32'(MAX_CELLS_PER_SIDE)) begin
            w_n32 = 32'(MAX_CELLS_PER_SIDE);
        end else begin
            w_n32 = 32'(r_cells);
        end
    end
    assign w_n = w_n32[NW-1:0];

    // ---------------- stage control ----------------
    logic r_in_v, r_pr_v, r_out_v;
    logic [NW:0] r_dv_v;
    logic w_mv_in, w_mv_pr, w_mv_out;
    logic [NW:0] w_mv_dv;

    always_comb begin
        w_mv_out = !r_out_v || o_cell.ready;
        w_mv_dv[NW] = !r_dv_v[NW] || w_mv_out;
        for (int s = NW - 1; s >= 0; s--) begin
            w_mv_dv[s] = !r_dv_v[s] || w_mv_dv[s+1];
        end
        w_mv_pr = !r_pr_v || w_mv_dv[0];
        w_mv_in = !r_in_v || w_mv_pr;
    end

    assign i_dir.ready = w_mv_in;

    // ---------------- stage 1: input register ----------------
    logic signed [DIR_W-1:0] r_in_x, r_in_y, r_in_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_mv_in) begin
            r_in_v <= i_dir.valid;
            r_in_x <= i_dir.dir_x;
            r_in_y <= i_dir.dir_y;
            r_in_z <= i_dir.dir_z;
        end
    end

    // ---------------- stage 2: face select and projection ----------------
    logic signed [PW:0]   w_x, w_y, w_z, w_ax, w_ay, w_az;
    logic signed [PW:0]   w_px, w_py, w_q, w_nc, w_nr;
    t_face                w_face;
    t_face                r_pr_face;
    logic [PW-1:0]        r_pr_nc, r_pr_nr;
    logic [DIR_W-1:0]     r_pr_q;

    always_comb begin
        w_x  = (PW+1)'(r_in_x);
        w_y  = (PW+1)'(r_in_y);
        w_z  = (PW+1)'(r_in_z);
        w_ax = (w_x < 0) ? -w_x : w_x;
        w_ay = (w_y < 0) ? -w_y : w_y;
        w_az = (w_z < 0) ? -w_z : w_z;
        // ties: z wins, then x
        if (w_az >= w_ax && w_az >= w_ay) begin
            w_q  = w_az;
            w_py = w_y;
            if (w_z > 0) begin
                w_face = FACE_POS_Z;
                w_px   = w_x;
            end else begin
                w_face = FACE_NEG_Z;
                w_px   = -w_x;
            end
            if (w_az == 0) begin
                // zero vector: centre of face +Z
                w_face = FACE_POS_Z;
                w_px   = '0;
                w_py   = '0;
                w_q    = (PW+1)'(1);
            end
        end else if (w_ax >= w_ay) begin
            w_q  = w_ax;
            w_py = w_y;
            if (w_x > 0) begin
                w_face = FACE_POS_X;
                w_px   = -w_z;
            end else begin
                w_face = FACE_NEG_X;
                w_px   = w_z;
            end
        end else begin
            w_q  = w_ay;
            w_px = w_x;
            if (w_y > 0) begin
                w_face = FACE_POS_Y;
                w_py   = -w_z;
            end else begin
                w_face = FACE_NEG_Y;
                w_py   = w_z;
            end
        end
        w_nc = w_px + w_q;   // 0 .. 2q
        w_nr = w_q - w_py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_v <= 1'b0;
        end else if (w_mv_pr) begin
            r_pr_v    <= r_in_v;
            r_pr_face <= w_face;
            r_pr_nc   <= w_nc[PW-1:0];
            r_pr_nr   <= w_nr[PW-1:0];
            r_pr_q    <= w_q[DIR_W-1:0];
        end
    end

    // ---------------- stage 3: scale by N, then divider stages ----------------
    // index 0 holds the scaled numerators, index s has quotient bit NW-s done
    t_face           r_dv_face [0:NW];
    logic [NUMW-1:0] r_dv_rc   [0:NW];
    logic [NUMW-1:0] r_dv_rr   [0:NW];
    logic [PW-1:0]   r_dv_den  [0:NW];
    logic [NW-1:0]   r_dv_qc   [0:NW];
    logic [NW-1:0]   r_dv_qr   [0:NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (w_mv_dv[0]) begin
            r_dv_v[0]    <= r_pr_v;
            r_dv_face[0] <= r_pr_face;
            r_dv_rc[0]   <= NUMW'(r_pr_nc) * NUMW'(w_n);
            r_dv_rr[0]   <= NUMW'(r_pr_nr) * NUMW'(w_n);
            r_dv_den[0]  <= {r_pr_q, 1'b0};
            r_dv_qc[0]   <= '0;
            r_dv_qr[0]   <= '0;
        end
    end

    for (genvar s = 1; s <= NW; s++) begin : g_div
        localparam int B = NW - s;
        logic [NUMW-1:0] w_sh;
        logic            w_gc, w_gr;

        assign w_sh = NUMW'(r_dv_den[s-1]) << B;
        assign w_gc = r_dv_rc[s-1] >= w_sh;
        assign w_gr = r_dv_rr[s-1] >= w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s] <= 1'b0;
            end else if (w_mv_dv[s]) begin
                r_dv_v[s]    <= r_dv_v[s-1];
                r_dv_face[s] <= r_dv_face[s-1];
                r_dv_den[s]  <= r_dv_den[s-1];
                r_dv_rc[s]   <= w_gc ? r_dv_rc[s-1] - w_sh : r_dv_rc[s-1];
                r_dv_rr[s]   <= w_gr ? r_dv_rr[s-1] - w_sh : r_dv_rr[s-1];
                r_dv_qc[s]   <= r_dv_qc[s-1] | (NW'(w_gc) << B);
                r_dv_qr[s]   <= r_dv_qr[s-1] | (NW'(w_gr) << B);
            end
        end
    end

    // ---------------- output stage: clamp to N-1 ----------------
    logic [NW-1:0]     w_cc, w_cr;
    logic [31:0]       w_cc32, w_cr32;
    t_face             r_out_face;
    logic [GRID_W-1:0] r_out_col, r_out_row;

    always_comb begin
        w_cc   = (r_dv_qc[NW] >= w_n) ? w_n - NW'(1) : r_dv_qc[NW];
        w_cr   = (r_dv_qr[NW] >= w_n) ? w_n - NW'(1) : r_dv_qr[NW];
        w_cc32 = 32'(w_cc);
        w_cr32 = 32'(w_cr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_mv_out) begin
            r_out_v    <= r_dv_v[NW];
            r_out_face <= r_dv_face[NW];
            r_out_col  <= w_cc32[GRID_W-1:0];
            r_out_row  <= w_cr32[GRID_W-1:0];
        end
    end

    assign o_cell.valid       = r_out_v;
    assign o_cell.face_index  = r_out_face;
    assign o_cell.grid_column = r_out_col;
    assign o_cell.grid_row    = r_out_row;

    // ---------------- assertions ----------------
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dir.valid && i_dir.ready) |=> r_in_v)
        else $error("accepted transaction did not enter the input stage");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pr_v |-> (r_pr_q != '0))
        else $error("zero divisor after projection");

    a_cell_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell.valid |-> (32'(o_cell.grid_column) < w_n32 && 32'(o_cell.grid_row) < w_n32))
        else $error("grid cell outside the face");

endmodule

`default_nettype wire

FILE: sim/cell_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cell_checker
// Watches the direction and cell channels and the register port, predicts
// the face and grid cell of every accepted direction and compares each
// delivered cell with the oldest prediction.
// ---------------------------------------------------------------------------

module cell_checker
    import cfgm_pkg::*;
#(
    parameter int MAX_CELLS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    cfgm_dir_if                i_dir_mon,
    cfgm_cell_if               i_cell_mon,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [APB_AW-1:0]  i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    input  logic [APB_DW-1:0]  i_prdata,
    input  logic               i_pready,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_errors
);

    localparam logic [APB_AW-1:0] CELLS_ADDR = {REG_CELLS_PER_SIDE, 2'b00};

    typedef struct packed {
        t_face              face;
        logic [GRID_W-1:0]  col;
        logic [GRID_W-1:0]  row;
    } t_cell_rec;

    t_cell_rec          cell_fifo[$];
    logic [CELL_W-1:0]  cells_cfg;
    int                 accepted_dirs;
    int                 delivered_cells;
    int                 err_count;

    assign o_pending = accepted_dirs - delivered_cells;
    assign o_checked = delivered_cells;
    assign o_errors  = err_count;

    // floor((num + span) * n / (2 * span)), top value pulled back to n-1
    function automatic logic [GRID_W-1:0] cell_from_ratio(input longint num,
                                                          input longint span,
                                                          input longint n);
        longint c;
        c = ((num + span) * n) / (2 * span);
        if (c > n - 1)
            c = n - 1;
        return c[GRID_W-1:0];
    endfunction

    function automatic t_cell_rec map_direction(input logic signed [DIR_W-1:0] dx,
                                                input logic signed [DIR_W-1:0] dy,
                                                input logic signed [DIR_W-1:0] dz,
                                                input logic [CELL_W-1:0]       size_reg);
        longint    x, y, z, ax, ay, az, n, lead, u, v, num_u, num_v, span;
        t_cell_rec res;
        x  = dx;
        y  = dy;
        z  = dz;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        n  = size_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_CELLS)
            n = MAX_CELLS;

        // ties resolve to z, then x, then y
        if (az >= ax && az >= ay) begin
            lead = z;
            if (z > 0) begin
                res.face = FACE_POS_Z; u = x;  v = y;
            end else begin
                res.face = FACE_NEG_Z; u = x;  v = -y;
            end
        end else if (ax >= ay && ax >= az) begin
            lead = x;
            if (x > 0) begin
                res.face = FACE_POS_X; u = -z; v = y;
            end else begin
                res.face = FACE_NEG_X; u = -z; v = -y;
            end
        end else begin
            lead = y;
            if (y > 0) begin
                res.face = FACE_POS_Y; u = x;  v = -z;
            end else begin
                res.face = FACE_NEG_Y; u = -x; v = -z;
            end
        end

        if (lead == 0) begin
            // all-zero vector lands in the middle of face +Z
            res.face = FACE_POS_Z;
            num_u = 0;
            num_v = 0;
            span  = 1;
        end else if (lead < 0) begin
            num_u = -u;
            num_v = -v;
            span  = -lead;
        end else begin
            num_u = u;
            num_v = v;
            span  = lead;
        end

        res.col = cell_from_ratio(num_u, span, n);
        res.row = cell_from_ratio(-num_v, span, n);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cell_rec want;
        int        mism;
        mism = 0;
        if (!i_rst_n) begin
            cells_cfg       <= CELL_W'(1);
            cell_fifo.delete();
            accepted_dirs   <= 0;
            delivered_cells <= 0;
            err_count       <= 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == CELLS_ADDR) begin
                if (i_pwrite) begin
                    cells_cfg <= i_pwdata[CELL_W-1:0];
                end else if (i_prdata !== APB_DW'(cells_cfg)) begin
                    $error("cells_per_side readback: expected %0d, got %0d",
                           cells_cfg, i_prdata);
                    mism++;
                end
            end

            // pop before push: a cell can never belong to this edge's direction
            if (i_cell_mon.valid && i_cell_mon.ready) begin
                delivered_cells <= delivered_cells + 1;
                if (cell_fifo.size() == 0) begin
                    $error("cell transaction with no direction outstanding");
                    mism++;
                end else begin
                    want = cell_fifo.pop_front();
                    if (i_cell_mon.face_index !== want.face) begin
                        $error("face_index: expected %0d, got %0d",
                               want.face, i_cell_mon.face_index);
                        mism++;
                    end
                    if (i_cell_mon.grid_column !== want.col) begin
                        $error("grid_column: expected %0d, got %0d",
                               want.col, i_cell_mon.grid_column);
                        mism++;
                    end
                    if (i_cell_mon.grid_row !== want.row) begin
                        $error("grid_row: expected %0d, got %0d",
                               want.row, i_cell_mon.grid_row);
                        mism++;
                    end
                end
            end

            if (i_dir_mon.valid && i_dir_mon.ready) begin
                cell_fifo.insert(cell_fifo.size(),
                                 map_direction(i_dir_mon.dir_x, i_dir_mon.dir_y,
                                               i_dir_mon.dir_z, cells_cfg));
                accepted_dirs <= accepted_dirs + 1;
            end

            if (mism != 0)
                err_count <= err_count + mism;
        end
    end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the cube face grid mapper: directed face, tie and edge
// directions, then biased random directions over a range of grid sizes,
// with random stalls on both channels. Checking sits in cell_checker.
// ---------------------------------------------------------------------------

module tb;
    import cfgm_pkg::*;

    localparam int                MAX_CELLS      = 1024;
    localparam int                SETTLE_CYCLES  = 20;     // pipeline depth plus margin
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                PHASES         = 12;
    localparam int                PHASE_ITEMS    = 110;
    localparam logic [APB_AW-1:0] CELLS_ADDR     = {REG_CELLS_PER_SIDE, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel, penable, pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int                 pending, checked, errors;
    int                 items_sent = 0;
    int                 quiet_cycles = 0;
    logic               src_idle_on  = 1'b0;
    logic               sink_idle_on = 1'b0;

    cfgm_dir_if  dir_bus ();
    cfgm_cell_if cell_bus ();

    always #5 clk = ~clk;

    cube_face_grid_mapper #(.MAX_CELLS_PER_SIDE(MAX_CELLS)) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_dir     (dir_bus),
        .o_cell    (cell_bus),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    cell_checker #(.MAX_CELLS(MAX_CELLS)) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_dir_mon  (dir_bus),
        .i_cell_mon (cell_bus),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_prdata   (prdata),
        .i_pready   (pready),
        .o_pending  (pending),
        .o_checked  (checked),
        .o_errors   (errors)
    );

    // any quiet spell longer than this means the block has hung
    always @(posedge clk) begin
        if ((dir_bus.valid && dir_bus.ready) || (cell_bus.valid && cell_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // cell sink: random stall before each transaction while sink_idle_on is set
    initial begin : cell_sink
        int gap;
        cell_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = sink_idle_on ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                cell_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cell_bus.ready <= 1'b1;
            @(posedge clk);
            while (!cell_bus.valid) @(posedge clk);
        end
    end

    task automatic apb_transfer(input logic wr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CELLS_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid_size(input int size);
        logic [APB_DW-1:0] data;
        data = $urandom_range(0, 1) ? $urandom() : '0;   // junk above the field
        data[CELL_W-1:0] = CELL_W'(size);
        apb_transfer(1'b1, data);
        apb_transfer(1'b0, '0);
    endtask

    task automatic send_dir(input int x, input int y, input int z);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            dir_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        dir_bus.valid <= 1'b1;
        dir_bus.dir_x <= DIR_W'(x);
        dir_bus.dir_y <= DIR_W'(y);
        dir_bus.dir_z <= DIR_W'(z);
        @(posedge clk);
        while (!dir_bus.ready) @(posedge clk);
        items_sent++;
    endtask

    // hold off until every predicted cell has been delivered
    task automatic drain();
        dir_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    task automatic send_random();
        int c[3];
        int t, kind;
        kind = $urandom_range(0, 9);
        case (kind)
            4, 5: begin
                // ties and face edges: components share one magnitude; kind 5 redraws one within it
                t = $urandom_range(0, 32767);
                for (int i = 0; i < 3; i++)
                    c[i] = $urandom_range(0, 1) ? t : -t;
                if (kind == 5)
                    c[$urandom_range(0, 2)] = $urandom_range(0, 2 * t) - t;
            end
            6: begin
                // most negative value leads, others anywhere
                for (int i = 0; i < 3; i++)
                    c[i] = $urandom_range(0, 65535) - 32768;
                c[$urandom_range(0, 2)] = -32768;
            end
            7: begin
                for (int i = 0; i < 3; i++)
                    c[i] = $urandom_range(0, 8) - 4;
            end
            8: begin
                for (int i = 0; i < 3; i++)
                    c[i] = pick_extreme();
            end
            default: begin
                for (int i = 0; i < 3; i++)
                    c[i] = $urandom_range(0, 65535) - 32768;
            end
        endcase
        send_dir(c[0], c[1], c[2]);
    endtask

    function automatic int grid_size_for(input int phase);
        case (phase)
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 3;
            4:       return 7;
            5:       return MAX_CELLS;
            6:       return MAX_CELLS + 1;
            7:       return 2047;
            8:       return MAX_CELLS - 1;
            11:      return 5;
            default: return $urandom_range(4, MAX_CELLS - 2);
        endcase
    endfunction

    initial begin : stimulus
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        dir_bus.valid <= 1'b0;
        dir_bus.dir_x <= '0;
        dir_bus.dir_y <= '0;
        dir_bus.dir_z <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset grid size of one
        apb_transfer(1'b0, '0);
        send_dir(0, 0, 0);
        send_dir(32767, 1, 2);
        send_dir(-32768, -32768, -32768);
        drain();

        // directed set on an 8x8 face
        set_grid_size(8);
        send_dir(0, 0, 0);                 // zero vector
        send_dir(0, 0, 32767);
        send_dir(0, 0, -32768);
        send_dir(32767, 0, 0);
        send_dir(-32768, 0, 0);
        send_dir(0, 32767, 0);
        send_dir(0, -32768, 0);
        send_dir(1000, 1000, 1000);        // three-way tie goes to z
        send_dir(-500, 200, 500);          // z/x tie
        send_dir(-700, 700, 100);          // x/y tie
        send_dir(32767, 0, 32767);         // right edge, column clamp
        send_dir(0, -32767, 32767);        // bottom edge, row clamp
        send_dir(-32768, -32768, -32768);
        send_dir(32767, 32767, -32768);
        send_dir(-32768, 32767, 32767);
        send_dir(1, -1, 0);
        send_dir(0, 1, -1);
        send_dir(-1, -1, -1);
        send_dir(12345, -23456, 30000);
        send_dir(-20000, 31000, -5000);
        send_dir(5000, -31000, -29000);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            set_grid_size(grid_size_for(ph));
            src_idle_on  = (ph % 3 != 0);
            sink_idle_on = (ph % 4 != 1);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_random();
                if (ph == 5 && k == PHASE_ITEMS / 2)
                    drain();
            end
        end
        drain();

        $display("%0d directions sent, %0d cells checked", items_sent, checked);
        $display("grid sizes from zero through past the %0d-cell cap, stalls on both sides",
                 MAX_CELLS);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
